// ----- rtl/core/mtc_pkg.sv -----
`timescale 1ns / 1ps

package mtc_pkg;

   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int TICK_BITS          = 12;
   localparam int NOM_BITS           = 15;
   localparam int QUAL_BITS          = 16;
   localparam int FRAC_BITS          = 8;

   localparam logic [TICK_BITS-1:0] TICK_TIME_RESET = 12'd100;

   typedef enum logic [2:0] {
      SYM_DOT    = 3'd0,
      SYM_DASH   = 3'd1,
      SYM_ESPACE = 3'd2,
      SYM_LSPACE = 3'd3,
      SYM_WSPACE = 3'd4
   } symbol_type;

endpackage

// ----- rtl/core/mtc_div.sv -----
`timescale 1ns / 1ps

module mtc_div #(
   parameter int COUNT_BITS = mtc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COUNT_BITS-1:0]           dividend,
   input  logic [mtc_pkg::NOM_BITS-1:0]    divisor,
   output logic                            done,
   output logic [mtc_pkg::QUAL_BITS-1:0]   quotient
);
   import mtc_pkg::*;

   localparam int NUM_BITS  = COUNT_BITS + FRAC_BITS;
   localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [NOM_BITS-1:0]  den_ff, den_in;
   logic [NOM_BITS-1:0]  rem_ff, rem_in;
   logic [QUAL_BITS-1:0] quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NOM_BITS:0]    trial;
   logic [NOM_BITS:0]    diff;
   logic                 qbit;

   // One restoring step per cycle; quotient bits that leave the top set overflow.
   always_comb begin
      trial = {rem_ff, num_ff[NUM_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = {dividend, {FRAC_BITS{1'b0}}};
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         rem_in = qbit ? diff[NOM_BITS-1:0] : trial[NOM_BITS-1:0];
         quo_in = {quo_ff[QUAL_BITS-2:0], qbit};
         ovf_in = ovf_ff | quo_ff[QUAL_BITS-1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? {QUAL_BITS{1'b1}} : quo_ff;

endmodule

// ----- rtl/core/morse_timing_classifier.sv -----
`timescale 1ns / 1ps
// A request that ends a timed period runs the bit-serial divider (28 divide steps at
// the default width) in ST_DIVIDE, waits in ST_HOLD for a free output, then responds.
// Any other request gives its response in the cycle after it is taken.
// One request per cycle while the output is not stalled; none while a symbol is divided.
// Reset is synchronous: key off, count zero, no transition seen, flag clear, tick 100.

module morse_timing_classifier #(
   parameter int COUNT_BITS = mtc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic                             req_key_on,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_symbol_valid,
   output logic [2:0]                       rsp_symbol,
   output logic [mtc_pkg::QUAL_BITS-1:0]    rsp_quality,
   output logic                             rsp_char_ready,
   output logic                             rsp_key_level,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mtc_pkg::TICK_BITS-1:0]    csr_data
);
   import mtc_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > QUAL_BITS) ? COUNT_BITS : QUAL_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type              state_ff, state_in;
   logic [TICK_BITS-1:0]   tick_time_ff, tick_time_in;
   logic                   key_state_ff, key_state_in;
   logic [COUNT_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                   seen_ff, seen_in;
   logic                   flag_ff, flag_in;
   symbol_type             pend_symbol_ff, pend_symbol_in;
   logic                   pend_ready_ff, pend_ready_in;
   logic [QUAL_BITS-1:0]   pend_quality_ff, pend_quality_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_sv_ff, rsp_sv_in;
   symbol_type             rsp_symbol_ff, rsp_symbol_in;
   logic [QUAL_BITS-1:0]   rsp_quality_ff, rsp_quality_in;
   logic                   rsp_ready_ff, rsp_ready_in;
   logic                   rsp_key_ff, rsp_key_in;

   logic                   accept;
   logic                   out_free;
   logic [TICK_BITS-1:0]   unit;
   logic [CMP_BITS-1:0]    t2, t3, t5, dt_cmp, el_n_cmp;
   logic [NOM_BITS-1:0]    n1, n3, n7, nominal;
   logic [COUNT_BITS-1:0]  dt;
   logic                   changed, do_sym, char_rdy_n;
   symbol_type             sym;
   logic                   div_start, div_done;
   logic [QUAL_BITS-1:0]   div_quotient;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      unit = (tick_time_ff == '0) ? TICK_BITS'(1) : tick_time_ff;
      n1   = NOM_BITS'(unit);
      n3   = NOM_BITS'({unit, 1'b0}) + NOM_BITS'(unit);
      n7   = NOM_BITS'({unit, 3'b000}) - NOM_BITS'(unit);
      t2   = CMP_BITS'({unit, 1'b0});
      t3   = CMP_BITS'(n3);
      t5   = CMP_BITS'({unit, 2'b00}) + CMP_BITS'(unit);
      dt   = (elapsed_ff == {COUNT_BITS{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;
      dt_cmp  = CMP_BITS'(dt);
      changed = !req_command && (req_key_on != key_state_ff);
      do_sym  = changed && seen_ff;

      if (!req_key_on) begin
         if (dt_cmp > t2) begin
            sym     = SYM_DASH;
            nominal = n3;
         end else begin
            sym     = SYM_DOT;
            nominal = n1;
         end
      end else if (dt_cmp < t2) begin
         sym     = SYM_ESPACE;
         nominal = n1;
      end else if (dt_cmp < t5) begin
         sym     = SYM_LSPACE;
         nominal = n3;
      end else begin
         sym     = SYM_WSPACE;
         nominal = n7;
      end

      key_state_in = key_state_ff;
      elapsed_in   = elapsed_ff;
      seen_in      = seen_ff;
      flag_in      = flag_ff;
      if (accept) begin
         if (req_command) begin
            flag_in = 1'b0;
         end else if (changed) begin
            key_state_in = req_key_on;
            elapsed_in   = '0;
            seen_in      = 1'b1;
            if (do_sym && (sym == SYM_LSPACE || sym == SYM_WSPACE)) begin
               flag_in = 1'b1;
            end
         end else begin
            elapsed_in = dt;
         end
      end
      el_n_cmp   = CMP_BITS'(elapsed_in);
      char_rdy_n = flag_in || (!key_state_in && (!seen_in || el_n_cmp >= t3));
      div_start  = accept && do_sym;
      tick_time_in = (csr_valid && csr_ready) ? csr_data : tick_time_ff;
   end

   mtc_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dt),
      .divisor  (nominal),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in        = state_ff;
      pend_symbol_in  = pend_symbol_ff;
      pend_ready_in   = pend_ready_ff;
      pend_quality_in = pend_quality_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_sv_in       = rsp_sv_ff;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_quality_in  = rsp_quality_ff;
      rsp_ready_in    = rsp_ready_ff;
      rsp_key_in      = rsp_key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (do_sym) begin
                  pend_symbol_in = sym;
                  pend_ready_in  = char_rdy_n;
                  state_in       = ST_DIVIDE;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_sv_in      = 1'b0;
                  rsp_symbol_in  = SYM_DOT;
                  rsp_quality_in = '0;
                  rsp_ready_in   = char_rdy_n;
                  rsp_key_in     = key_state_in;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               pend_quality_in = div_quotient;
               state_in        = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sv_in      = 1'b1;
               rsp_symbol_in  = pend_symbol_ff;
               rsp_quality_in = pend_quality_ff;
               rsp_ready_in   = pend_ready_ff;
               rsp_key_in     = key_state_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_symbol_ff  <= pend_symbol_in;
      pend_ready_ff   <= pend_ready_in;
      pend_quality_ff <= pend_quality_in;
      rsp_sv_ff       <= rsp_sv_in;
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_quality_ff  <= rsp_quality_in;
      rsp_ready_ff    <= rsp_ready_in;
      rsp_key_ff      <= rsp_key_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_time_ff <= TICK_TIME_RESET;
         key_state_ff <= 1'b0;
         elapsed_ff   <= '0;
         seen_ff      <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_time_ff <= tick_time_in;
         key_state_ff <= key_state_in;
         elapsed_ff   <= elapsed_in;
         seen_ff      <= seen_in;
         flag_ff      <= flag_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_valid = rsp_sv_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_quality      = rsp_quality_ff;
   assign rsp_char_ready   = rsp_ready_ff;
   assign rsp_key_level    = rsp_key_ff;

   a_no_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_symbol_valid |-> rsp_symbol == SYM_DOT && rsp_quality == '0)
      else $error("response without symbol carries nonzero fields");

   a_space_sets_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_valid
      && (rsp_symbol == SYM_LSPACE || rsp_symbol == SYM_WSPACE) |-> rsp_char_ready)
      else $error("letter or word space without char ready");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside of divide state");

   a_take_keeps_time: assert property (@(posedge clock) disable iff (reset)
      accept && req_command |=> $stable(elapsed_ff) && $stable(key_state_ff) && !flag_ff)
      else $error("take request changed timing state");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import mtc_pkg::*;

   localparam int   COUNT_BITS      = COUNT_BITS_DEFAULT;
   localparam logic CMD_SAMPLE      = 1'b0;
   localparam logic CMD_TAKE        = 1'b1;
   localparam int   HOLD_OFF_CYCLES = 400;
   localparam int   WATCHDOG_LIMIT  = 5000;
   localparam int   SETTLE_CYCLES   = COUNT_BITS + 11 + 8;

   typedef struct {
      logic                 symbol_valid;
      symbol_type           symbol;
      logic [QUAL_BITS-1:0] quality;
      logic                 char_ready;
      logic                 key_level;
   } morse_response_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_command = 1'b0;
   logic                  req_key_on  = 1'b0;
   logic                  rsp_ready   = 1'b0;
   logic                  csr_valid   = 1'b0;
   logic [TICK_BITS-1:0]  csr_data    = '0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_symbol_valid;
   logic [2:0]            rsp_symbol;
   logic [QUAL_BITS-1:0]  rsp_quality;
   logic                  rsp_char_ready;
   logic                  rsp_key_level;
   logic                  csr_ready;

   morse_response_type awaited_responses[$];
   int  mismatches   = 0;
   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   int  stall_left   = 0;
   bit  stall_pending = 1'b0;
   int  quiet_cycles = 0;

   // Shadow copy of the classifier state.
   logic [TICK_BITS-1:0]  dot_unit;
   logic                  key_held;
   logic [COUNT_BITS-1:0] ticks_since;
   logic                  change_seen;
   logic                  letter_flag;

   morse_timing_classifier #(
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_key_on       (req_key_on),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_quality      (rsp_quality),
      .rsp_char_ready   (rsp_char_ready),
      .rsp_key_level    (rsp_key_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [QUAL_BITS-1:0] ratio_q8(longint unsigned dt,
                                                     longint unsigned nominal);
      longint unsigned q;
      q = (dt << 8) / nominal;
      return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic morse_response_type classify_sample(logic command, logic key);
      morse_response_type r;
      longint unsigned dt;
      longint unsigned unit;
      r.symbol_valid = 1'b0;
      r.symbol       = SYM_DOT;
      r.quality      = '0;
      unit = (dot_unit == 0) ? 1 : dot_unit;
      if (command == CMD_TAKE) begin
         letter_flag = 1'b0;
      end else begin
         if (ticks_since != '1) begin
            ticks_since = ticks_since + 1'b1;
         end
         if (key != key_held) begin
            if (change_seen) begin
               dt = ticks_since;
               r.symbol_valid = 1'b1;
               if (!key) begin
                  if (dt > 2 * unit) begin
                     r.symbol  = SYM_DASH;
                     r.quality = ratio_q8(dt, 3 * unit);
                  end else begin
                     r.symbol  = SYM_DOT;
                     r.quality = ratio_q8(dt, unit);
                  end
               end else if (dt < 2 * unit) begin
                  r.symbol  = SYM_ESPACE;
                  r.quality = ratio_q8(dt, unit);
               end else if (dt < 5 * unit) begin
                  r.symbol  = SYM_LSPACE;
                  r.quality = ratio_q8(dt, 3 * unit);
               end else begin
                  r.symbol  = SYM_WSPACE;
                  r.quality = ratio_q8(dt, 7 * unit);
               end
               if (r.symbol == SYM_LSPACE || r.symbol == SYM_WSPACE) begin
                  letter_flag = 1'b1;
               end
            end
            change_seen = 1'b1;
            ticks_since = '0;
            key_held    = key;
         end
      end
      r.char_ready = letter_flag ||
                     (!key_held && (!change_seen || ticks_since >= 3 * unit));
      r.key_level  = key_held;
      return r;
   endfunction

   // Result receiver: random idling, plus a long hold-off on demand.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_pending) begin
         stall_pending = 1'b0;
         stall_left    = HOLD_OFF_CYCLES - 1;
         rsp_ready    <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      morse_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = awaited_responses.pop_front();
            compare_field("symbol_valid", want.symbol_valid, rsp_symbol_valid);
            compare_field("symbol", want.symbol, rsp_symbol);
            compare_field("quality", want.quality, rsp_quality);
            compare_field("char_ready", want.char_ready, rsp_char_ready);
            compare_field("key_level", want.key_level, rsp_key_level);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(logic command, logic key);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_key_on  <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_responses.insert(awaited_responses.size(), classify_sample(command, key));
   endtask

   task automatic hold_key(logic level, int samples);
      repeat (samples) send_item(CMD_SAMPLE, level);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_tick_time(logic [TICK_BITS-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dot_unit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_item(CMD_TAKE, 1'b1);
      hold_key(1'b0, 1);
      hold_key(1'b1, 2);
      hold_key(1'b0, 1);
   endtask

   task automatic test_symbol_classes();
      write_tick_time(12'd1);
      hold_key(1'b1, 1);
      hold_key(1'b0, 2);
      hold_key(1'b1, 2);
      send_item(CMD_TAKE, 1'b0);
      hold_key(1'b0, 3);
      hold_key(1'b1, 5);
      hold_key(1'b0, 5);
      hold_key(1'b1, 1);
      send_item(CMD_TAKE, 1'b1);
   endtask

   task automatic test_tick_extremes();
      write_tick_time(12'd0);
      hold_key(1'b0, 1);
      hold_key(1'b1, 3);
      hold_key(1'b0, 6);
      hold_key(1'b1, 1);
      write_tick_time(12'd4095);
      hold_key(1'b0, 2);
      hold_key(1'b1, 3);
      hold_key(1'b0, 3);
      hold_key(1'b1, 1);
   endtask

   task automatic test_quality_saturation();
      write_tick_time(12'd1);
      hold_key(1'b0, 1);
      hold_key(1'b1, 768);
      hold_key(1'b0, 1);
   endtask

   task automatic test_random_traffic(int chunks);
      int unsigned unit;
      int unsigned units;
      int          len;
      int          pick;
      int          sent;
      logic        level;
      repeat (chunks) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            write_tick_time(12'd0);
         end else if (pick == 1) begin
            write_tick_time(12'($urandom_range(7, 24)));
         end else begin
            write_tick_time(12'($urandom_range(1, 4)));
         end
         unit = (dot_unit == 0) ? 1 : dot_unit;
         sent = 0;
         while (sent < 70) begin
            level = !key_held;
            pick  = $urandom_range(99);
            if (pick < 6) begin
               send_item(CMD_TAKE, 1'($urandom_range(1)));
               len = 1;
            end else if (pick < 12) begin
               send_item(CMD_SAMPLE, 1'($urandom_range(1)));
               len = 1;
            end else if (pick < 22) begin
               len = $urandom_range(1, 8 * unit + 2);
               hold_key(level, len);
            end else begin
               if (level) begin
                  units = $urandom_range(1) ? 1 : 3;
               end else begin
                  pick  = $urandom_range(9);
                  units = (pick < 5) ? 1 : (pick < 8) ? 3 : 7;
               end
               len = units * unit + $urandom_range(0, unit) - unit / 2;
               if (len < 1) len = 1;
               hold_key(level, len);
            end
            sent += len;
         end
      end
   endtask

   task automatic test_backpressure();
      write_tick_time(12'd1);
      stall_pending = 1'b1;
      repeat (60) send_item(CMD_SAMPLE, 1'($urandom_range(1)));
      drain_responses();
      repeat (20) send_item(CMD_SAMPLE, 1'($urandom_range(1)));
   endtask

   initial begin
      dot_unit    = TICK_TIME_RESET;
      key_held    = 1'b0;
      ticks_since = '0;
      change_seen = 1'b0;
      letter_flag = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 19;
      rsp_idle_pct = 53;
      test_reset_defaults();
      test_symbol_classes();
      test_tick_extremes();
      test_quality_saturation();

      req_idle_pct = 53;
      rsp_idle_pct = 19;
      test_random_traffic(2);
      test_backpressure();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(2);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
